@@ rtl/fit_strategy_block_allocator_unit_macros.svh @@
// assertion macros
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FSBA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define FSBA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define FSBA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define FSBA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

@@ rtl/fsba_pkg.sv @@
`default_nettype none
package fsba_pkg;
  localparam int unsigned PoolBytes   = 1024;
  localparam int unsigned MinUnit     = 16;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned MaxBlocks   = 32;
  localparam int unsigned AddrW       = 10;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST  = 2'd0,
    FIT_BEST   = 2'd1,
    FIT_WORST  = 2'd2,
    FIT_UNUSED = 2'd3
  } fit_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_SHIFT_UP, ST_SPLIT, ST_FREE_NEXT,
    ST_FREE_PREV, ST_SHIFT_DN, ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rst;
    logic scan_step;
    logic do_decide;
    logic shift_up_step;
    logic do_split;
    logic merge_next;
    logic merge_prev;
    logic shift_dn_step;
  } cmd_t;

  typedef struct packed {
    logic is_free_mode;
    logic addr_zero;
    logic scan_done;
    logic found;
    logic split_needed;
    logic next_merge;
    logic prev_merge;
    logic shift_done;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/fsba_if.sv @@
`default_nettype none
interface fsba_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] fit_strategy;
  logic [9:0] request_size;
  logic [9:0] block_address;
  modport source (output valid, mode, fit_strategy, request_size, block_address,
                  input ready);
  modport sink (input valid, mode, fit_strategy, request_size, block_address,
                output ready);
endinterface

interface fsba_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [9:0] payload_address;
  modport source (output valid, status, payload_address, input ready);
  modport sink (input valid, status, payload_address, output ready);
endinterface
`default_nettype wire

@@ rtl/fsba_ctrl.sv @@
`default_nettype none
module fsba_ctrl import fsba_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output logic res_fail,
  output logic res_set,
  output cmd_t cmd,
  input  sts_t sts
);
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    res_fail      = 1'b0;
    res_set       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.is_free_mode && sts.addr_zero) begin
          state_nxt = ST_RESULT;
        end else if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!sts.found) begin
          res_fail  = 1'b1;
          state_nxt = ST_RESULT;
        end else if (sts.is_free_mode) begin
          state_nxt = ST_FREE_NEXT;
        end else if (sts.split_needed) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = ST_SHIFT_UP;
        end else begin
          cmd.do_decide = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_SHIFT_UP: begin
        if (sts.shift_done) begin
          state_nxt = ST_SPLIT;
        end else begin
          cmd.shift_up_step = 1'b1;
        end
      end
      ST_SPLIT: begin
        cmd.do_split = 1'b1;
        state_nxt    = ST_RESULT;
      end
      ST_FREE_NEXT: begin
        cmd.merge_next = 1'b1;
        state_nxt      = sts.next_merge ? ST_SHIFT_DN : ST_FREE_PREV;
      end
      ST_SHIFT_DN: begin
        if (sts.shift_done) begin
          state_nxt = ST_FREE_PREV;
        end else begin
          cmd.shift_dn_step = 1'b1;
        end
      end
      ST_FREE_PREV: begin
        cmd.merge_prev = 1'b1;
        state_nxt      = sts.prev_merge ? ST_SHIFT_DN : ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          res_set       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/fsba_dp.sv @@
`default_nettype none
module fsba_dp import fsba_pkg::*; #(
  parameter int unsigned POOL_BYTES   = PoolBytes,
  parameter int unsigned MIN_UNIT     = MinUnit,
  parameter int unsigned HEADER_BYTES = HeaderBytes,
  parameter int unsigned MAX_BLOCKS   = MaxBlocks
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_mode,
  input  wire  [1:0] in_fit_strategy,
  input  wire  [9:0] in_request_size,
  input  wire  [9:0] in_block_address,
  input  wire        res_fail,
  input  wire        res_set,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_status,
  output logic [9:0] out_payload_address
);
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = $clog2(POOL_BYTES + 1) + 1;
  localparam int unsigned UW = $clog2(MIN_UNIT);
  localparam int unsigned RW = AddrW + 1 - UW;

  // table as per-entry registers, moved by single-step shifts
  logic [SW-1:0] start_r [MAX_BLOCKS];
  logic [SW-1:0] size_r  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] free_r;
  logic [CW-1:0] count_r;

  logic          mode_r;
  logic [1:0]    fit_r;
  logic [SW-1:0] need_r;
  logic [SW-1:0] addr_r;
  logic [CW-1:0] i_r;
  logic [IW-1:0] pick_r;
  logic          found_r;
  logic [CW-1:0] k_r;
  logic          fail_r;
  logic          status_r;
  logic [9:0]    pay_r;
  logic [9:0]    pay_res_r;

  logic [IW-1:0] ii;
  logic [SW-1:0] cur_size, cur_start, pick_size, pick_start;
  logic          cur_fit, better;
  logic [RW-1:0] units_c;
  logic [SW-1:0] need_c;
  logic [IW-1:0] pk1, pkm1;

  assign ii         = i_r[IW-1:0];
  assign cur_size   = size_r[ii];
  assign cur_start  = start_r[ii];
  assign pick_size  = size_r[pick_r];
  assign pick_start = start_r[pick_r];
  assign pk1        = pick_r + IW'(1);
  assign pkm1       = pick_r - IW'(1);
  assign cur_fit    = free_r[ii] && (cur_size >= need_r);
  always_comb begin
    better = 1'b0;
    if (cur_fit) begin
      if (!found_r) better = 1'b1;
      else if (fit_r == FIT_BEST && cur_size < pick_size) better = 1'b1;
      else if (fit_r == FIT_WORST && cur_size > pick_size) better = 1'b1;
    end
  end

  assign units_c = {1'b0, in_request_size[9:UW]} + RW'(|in_request_size[UW-1:0]);
  assign need_c  = SW'({units_c, {UW{1'b0}}});

  always_comb begin
    sts.is_free_mode = mode_r;
    sts.addr_zero    = (addr_r == '0);
    sts.scan_done    = (i_r >= count_r) ||
                       (found_r && (mode_r || fit_r == FIT_FIRST)) ||
                       (!mode_r && fit_r == FIT_UNUSED);
    sts.found        = found_r && !(!mode_r && fit_r == FIT_UNUSED);
    sts.split_needed = (pick_size > need_r + SW'(HEADER_BYTES + MIN_UNIT)) &&
                       (count_r < CW'(MAX_BLOCKS));
    sts.next_merge   = (CW'(pick_r) + CW'(1) < count_r) && free_r[pk1];
    sts.prev_merge   = (pick_r != '0) && free_r[pkm1];
    sts.shift_done   = mode_r ? (k_r >= count_r) : (k_r <= CW'(pick_r) + CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= CW'(1);
      start_r[0] <= '0;
      size_r[0]  <= SW'(POOL_BYTES - HEADER_BYTES);
      free_r     <= MAX_BLOCKS'(1);
      status_r   <= 1'b0;
      pay_res_r  <= '0;
    end else begin
      if (cmd.load) begin
        mode_r  <= in_mode;
        fit_r   <= in_fit_strategy;
        need_r  <= need_c;
        addr_r  <= SW'(in_block_address);
        i_r     <= '0;
        found_r <= 1'b0;
        pick_r  <= '0;
        fail_r  <= 1'b0;
      end
      if (cmd.scan_step) begin
        i_r <= i_r + CW'(1);
        if (mode_r) begin
          if (cur_start + SW'(HEADER_BYTES) == addr_r) begin
            found_r <= 1'b1;
            pick_r  <= ii;
          end
        end else if (better) begin
          found_r <= 1'b1;
          pick_r  <= ii;
        end
      end
      if (cmd.do_decide) begin
        free_r[pick_r] <= 1'b0;
        pay_r <= 10'(pick_start + SW'(HEADER_BYTES));
      end
      if (cmd.scan_rst) k_r <= count_r;
      if (cmd.shift_up_step) begin
        start_r[k_r[IW-1:0]] <= start_r[k_r[IW-1:0] - IW'(1)];
        size_r[k_r[IW-1:0]]  <= size_r[k_r[IW-1:0] - IW'(1)];
        free_r[k_r[IW-1:0]]  <= free_r[k_r[IW-1:0] - IW'(1)];
        k_r <= k_r - CW'(1);
      end
      if (cmd.do_split) begin
        start_r[pk1] <= pick_start + SW'(HEADER_BYTES) + need_r;
        size_r[pk1]  <= pick_size - need_r - SW'(HEADER_BYTES);
        free_r[pk1]  <= 1'b1;
        size_r[pick_r] <= need_r;
        free_r[pick_r] <= 1'b0;
        count_r <= count_r + CW'(1);
        pay_r <= 10'(pick_start + SW'(HEADER_BYTES));
      end
      // count drops when a merge removes an entry
      if (cmd.merge_next) begin
        free_r[pick_r] <= 1'b1;
        if (sts.next_merge) begin
          size_r[pick_r] <= pick_size + SW'(HEADER_BYTES) + size_r[pk1];
          k_r     <= CW'(pk1);
          count_r <= count_r - CW'(1);
        end
      end
      if (cmd.merge_prev && sts.prev_merge) begin
        size_r[pkm1] <= size_r[pkm1] + SW'(HEADER_BYTES) + pick_size;
        k_r     <= CW'(pick_r);
        pick_r  <= pkm1;
        count_r <= count_r - CW'(1);
      end
      if (cmd.shift_dn_step) begin
        start_r[k_r[IW-1:0]] <= start_r[k_r[IW-1:0] + IW'(1)];
        size_r[k_r[IW-1:0]]  <= size_r[k_r[IW-1:0] + IW'(1)];
        free_r[k_r[IW-1:0]]  <= free_r[k_r[IW-1:0] + IW'(1)];
        k_r <= k_r + CW'(1);
      end
      if (res_fail) fail_r <= 1'b1;
      if (res_set) begin
        status_r  <= fail_r;
        pay_res_r <= (fail_r || mode_r) ? 10'd0 : pay_r;
      end
    end
  end

  assign out_status          = status_r;
  assign out_payload_address = pay_res_r;
endmodule
`default_nettype wire

@@ rtl/fit_strategy_block_allocator_unit.sv @@
// fit-strategy block allocator
// per item: table scan, then one entry shift a cycle when a split or merge moves the table
// throughput: one item at a time; next item taken the cycle after the result is registered
// reset: synchronous active-low rst_n; table holds one free block spanning the pool
`default_nettype none
`include "fit_strategy_block_allocator_unit_macros.svh"
module fit_strategy_block_allocator_unit import fsba_pkg::*; #(
  parameter int unsigned POOL_BYTES   = PoolBytes,
  parameter int unsigned MIN_UNIT     = MinUnit,
  parameter int unsigned HEADER_BYTES = HeaderBytes,
  parameter int unsigned MAX_BLOCKS   = MaxBlocks
) (
  input wire clk,
  input wire rst_n,
  fsba_in_if.sink    in_ch,
  fsba_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;
  logic res_fail, res_set;

  fsba_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .res_fail, .res_set, .cmd, .sts
  );

  fsba_dp #(
    .POOL_BYTES(POOL_BYTES), .MIN_UNIT(MIN_UNIT),
    .HEADER_BYTES(HEADER_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk, .rst_n,
    .in_mode(in_ch.mode), .in_fit_strategy(in_ch.fit_strategy),
    .in_request_size(in_ch.request_size), .in_block_address(in_ch.block_address),
    .res_fail, .res_set, .cmd, .sts,
    .out_status(out_ch.status), .out_payload_address(out_ch.payload_address)
  );

  `FSBA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_ch.valid && out_ch.status, out_ch.payload_address == 10'd0, "failed result with address")
  `FSBA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted while busy")
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
  import fsba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       mode;
    logic [1:0] fit;
    logic [9:0] req;
    logic [9:0] addr;
    bit         hold;
  } alloc_req_t;

  typedef struct {
    logic       status;
    logic [9:0] payload;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fsba_in_if  in_ch();
  fsba_out_if out_ch();

  fit_strategy_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int total_reqs;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int errors = 0;
  bit gen_done = 1'b0;

  // shadow of the block table
  int unsigned tbl_start[MaxBlocks + 1];
  int unsigned tbl_size[MaxBlocks + 1];
  bit          tbl_free[MaxBlocks + 1];
  int unsigned tbl_count;

  function automatic void tbl_reset();
    for (int i = 0; i <= MaxBlocks; i++) begin
      tbl_start[i] = 0;
      tbl_size[i] = 0;
      tbl_free[i] = 1'b0;
    end
    tbl_size[0] = PoolBytes - HeaderBytes;
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic void tbl_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count && k + 1 < MaxBlocks; k++) begin
      tbl_start[k] = tbl_start[k + 1];
      tbl_size[k] = tbl_size[k + 1];
      tbl_free[k] = tbl_free[k + 1];
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic alloc_rsp_t predict_alloc(logic [1:0] fit, logic [9:0] req);
    alloc_rsp_t r;
    int unsigned need;
    int unsigned pick;
    bit found;
    need = ((int'(req) + MinUnit - 1) / MinUnit) * MinUnit;
    pick = 0;
    found = 1'b0;
    r.status = 1'b1;
    r.payload = '0;
    if (fit != FIT_FIRST && fit != FIT_BEST && fit != FIT_WORST) return r;
    for (int unsigned i = 0; i < tbl_count && i < MaxBlocks; i++) begin
      if (!tbl_free[i] || tbl_size[i] < need) continue;
      if (!found || (fit == FIT_BEST && tbl_size[i] < tbl_size[pick]) ||
          (fit == FIT_WORST && tbl_size[i] > tbl_size[pick])) begin
        pick = i;
        found = 1'b1;
        if (fit == FIT_FIRST) break;
      end
    end
    if (!found) return r;
    if (tbl_size[pick] > need + HeaderBytes + MinUnit && tbl_count < MaxBlocks) begin
      for (int unsigned k = tbl_count; k > pick + 1; k--) begin
        tbl_start[k] = tbl_start[k - 1];
        tbl_size[k] = tbl_size[k - 1];
        tbl_free[k] = tbl_free[k - 1];
      end
      tbl_start[pick + 1] = tbl_start[pick] + HeaderBytes + need;
      tbl_size[pick + 1] = tbl_size[pick] - need - HeaderBytes;
      tbl_free[pick + 1] = 1'b1;
      tbl_count++;
      tbl_size[pick] = need;
    end
    tbl_free[pick] = 1'b0;
    r.status = 1'b0;
    r.payload = 10'((tbl_start[pick] + HeaderBytes) & 'h3FF);
    return r;
  endfunction

  function automatic alloc_rsp_t predict_free(logic [9:0] addr);
    alloc_rsp_t r;
    int unsigned idx;
    bit found;
    idx = 0;
    found = 1'b0;
    r.payload = '0;
    r.status = 1'b0;
    if (addr == 0) return r;
    for (int unsigned i = 0; i < tbl_count && i < MaxBlocks; i++) begin
      if (tbl_start[i] + HeaderBytes == addr) begin
        idx = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      r.status = 1'b1;
      return r;
    end
    tbl_free[idx] = 1'b1;
    if (idx + 1 < tbl_count && tbl_free[idx + 1]) begin
      tbl_size[idx] += HeaderBytes + tbl_size[idx + 1];
      tbl_remove(idx + 1);
    end
    if (idx > 0 && tbl_free[idx - 1]) begin
      tbl_size[idx - 1] += HeaderBytes + tbl_size[idx];
      tbl_remove(idx);
    end
    return r;
  endfunction

  task automatic push_req(logic mode, logic [1:0] fit, logic [9:0] req, logic [9:0] addr,
                          bit hold = 1'b0);
    alloc_req_t t;
    t.mode = mode;
    t.fit = fit;
    t.req = req;
    t.addr = addr;
    t.hold = hold;
    pending_reqs.push_back(t);
    if (mode == MODE_ALLOC) expected_rsps.push_back(predict_alloc(fit, req));
    else expected_rsps.push_back(predict_free(addr));
  endtask

  function automatic logic [9:0] pick_used_addr(bit want_free);
    int unsigned cands[$];
    for (int unsigned i = 0; i < tbl_count; i++)
      if (tbl_free[i] == want_free) cands.push_back(tbl_start[i] + HeaderBytes);
    if (cands.size() == 0) return 10'd0;
    return 10'(cands[$urandom_range(cands.size() - 1)]);
  endfunction

  initial begin
    int r;
    logic [9:0] sz;
    tbl_reset();
    // directed
    push_req(MODE_ALLOC, FIT_FIRST, 10'd1023, 10'd0);
    push_req(MODE_ALLOC, FIT_FIRST, 10'd1000, 10'd0);
    push_req(MODE_ALLOC, FIT_FIRST, 10'd992, 10'd0);
    push_req(MODE_FREE, FIT_FIRST, 10'd0, 10'd24);
    push_req(MODE_FREE, FIT_FIRST, 10'd0, 10'd24);
    push_req(MODE_FREE, FIT_FIRST, 10'd0, 10'd0);
    push_req(MODE_FREE, FIT_FIRST, 10'd0, 10'h3FF);
    push_req(MODE_ALLOC, FIT_UNUSED, 10'd16, 10'd0);
    push_req(MODE_ALLOC, FIT_FIRST, 10'd0, 10'd0);
    push_req(MODE_ALLOC, FIT_FIRST, 10'd1, 10'd0);
    push_req(MODE_ALLOC, FIT_FIRST, 10'd100, 10'd0);
    push_req(MODE_ALLOC, FIT_FIRST, 10'd17, 10'd0);
    push_req(MODE_FREE, FIT_FIRST, 10'd0, 10'd64);
    push_req(MODE_ALLOC, FIT_BEST, 10'd8, 10'd0);
    push_req(MODE_ALLOC, FIT_WORST, 10'd8, 10'd0);
    push_req(MODE_ALLOC, FIT_BEST, 10'd0, 10'd0, 1'b1);
    push_req(MODE_ALLOC, FIT_WORST, 10'd0, 10'd0);
    push_req(MODE_FREE, FIT_WORST, 10'h3FF, 10'd25);
    push_req(MODE_FREE, FIT_BEST, 10'd0, pick_used_addr(1'b0));
    push_req(MODE_FREE, FIT_BEST, 10'd0, pick_used_addr(1'b0));
    // random
    for (int n = 0; n < 850; n++) begin
      r = $urandom_range(99);
      if (n % 200 == 120) begin
        // burst of size-0 and size-1 requests to fill the table
        for (int z = 0; z < 40; z++)
          push_req(MODE_ALLOC, 2'($urandom_range(2)), 10'($urandom_range(0, 3) == 0), 10'd0);
        n += 40;
      end else if (r < 45) begin
        case ($urandom_range(9))
          0: sz = 10'($urandom);
          1: sz = 10'd0;
          default: sz = 10'($urandom_range(0, 120));
        endcase
        push_req(MODE_ALLOC, ($urandom_range(19) == 0) ? FIT_UNUSED : 2'($urandom_range(2)),
                 sz, 10'($urandom), n == 400);
      end else if (r < 85) begin
        push_req(MODE_FREE, 2'($urandom), 10'($urandom), pick_used_addr(1'b0));
      end else if (r < 90) begin
        push_req(MODE_FREE, 2'($urandom), 10'($urandom), pick_used_addr(1'b1));
      end else if (r < 93) begin
        push_req(MODE_FREE, 2'($urandom), 10'($urandom), 10'd0);
      end else begin
        push_req(MODE_FREE, 2'($urandom), 10'($urandom), 10'($urandom));
      end
    end
    total_reqs = pending_reqs.size();
    gen_done = 1'b1;
  end

  int phase;
  always_comb phase = (total_reqs == 0) ? 0 : (sent_cnt * 3) / total_reqs;

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= 1'b0;
      in_ch.fit_strategy <= '0;
      in_ch.request_size <= '0;
      in_ch.block_address <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) sent_cnt <= sent_cnt + 1;
      if (!in_ch.valid || in_ch.ready) begin
        if (gen_done && pending_reqs.size() > 0 &&
            !(pending_reqs[0].hold && recv_cnt != sent_cnt + (in_ch.valid ? 1 : 0)) &&
            !(phase == 0 && $urandom_range(99) < 36) &&
            !(phase == 1 && $urandom_range(99) < 88)) begin
          alloc_req_t t;
          t = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= t.mode;
          in_ch.fit_strategy <= t.fit;
          in_ch.request_size <= t.req;
          in_ch.block_address <= t.addr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (phase == 0) out_ch.ready <= ($urandom_range(99) >= 88);
      else if (phase == 1) out_ch.ready <= ($urandom_range(99) >= 36);
      else out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_rsps.size() == 0) begin
          $display("%t: unexpected transfer status=%0d payload=%0d", $realtime,
                   out_ch.status, out_ch.payload_address);
          errors++;
        end else begin
          alloc_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_ch.status !== e.status) begin
            $display("%t: status expected %0d actual %0d", $realtime, e.status, out_ch.status);
            errors++;
          end
          if (out_ch.payload_address !== e.payload) begin
            $display("%t: payload expected %0d actual %0d", $realtime, e.payload,
                     out_ch.payload_address);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (gen_done);
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("[fit_strategy_block_allocator_unit] OK");
    end else begin
      $display("[fit_strategy_block_allocator_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[fit_strategy_block_allocator_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
